/* rtl/deqvs_pkg.sv */
`default_nettype none
package deqvs_pkg;

   localparam int VALUE_W = 32;
   localparam int REQ_W   = 3;
   localparam int POS_W   = 4;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   localparam logic [REQ_W-1:0] REQ_INSERT_FRONT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT_BACK  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE_FRONT = 3'd2;
   localparam logic [REQ_W-1:0] REQ_REMOVE_BACK  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SEARCH       = 3'd4;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0]          req_type;
      logic signed [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] removed_value;
      logic                      found;
      logic [POS_W-1:0]          position;
      logic [STAT_W-1:0]         status;
      logic [COUNT_W-1:0]        count;
   } rsp_payload_type;

   typedef struct packed {
      logic shift_right;
      logic shift_left;
      logic load;
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* rtl/deque_with_value_search.sv */
// Bounded double-ended queue of signed 32-bit values with value search.
// Input channel req_*: one request carries req_type (insert front/back,
// remove front/back, search) and a value. Result channel rsp_*: exactly one
// response per request with removed value, found flag, position of the first
// match counted from the front, status and element count after the request.
// Elements sit in a row of DEPTH cells ordered from the front; front inserts
// and front removals shift the whole row by one cell, a back insert loads the
// cell at the count, and search compares every cell against the key in parallel.
// A request is registered at acceptance and executed from that register; its
// response is written to the output register and is valid from there on.
// One request is in flight at a time: req_stall stays high while the
// registered request waits or executes, so a new request is accepted only
// after the previous one has executed.
// A stalled response holds in the output register; the pending request
// then waits and req_stall stays high until the response is taken.
// Reset empties the queue (count zero); cell contents are not cleared.
`default_nettype none
module deque_with_value_search
   import deqvs_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                      op_valid_ff, op_valid_in;
   req_payload_type           op_ff, op_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_ff, rsp_in;

   cell_ctrl_type             ctrl [DEPTH];
   logic signed [VALUE_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]          cell_match;

   logic                      execute;
   logic                      is_full;
   logic                      is_empty;
   logic [CW-1:0]             last_idx;
   logic signed [VALUE_W-1:0] back_value;
   logic                      hit;
   logic [IW-1:0]             hit_idx;
   logic [31:0]               hit_wide;
   logic [31:0]               cnt_wide;

   assign execute   = op_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = op_valid_ff;
   assign is_full   = (cnt_ff == CW'(DEPTH));
   assign is_empty  = (cnt_ff == '0);
   assign last_idx  = cnt_ff - CW'(1);

   // per-cell shift and load controls
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ctrl[i] = '0;
         if (execute) begin
            case (op_ff.req_type)
               REQ_INSERT_FRONT: ctrl[i].shift_right = !is_full;
               REQ_INSERT_BACK:  ctrl[i].load = !is_full && (CW'(i) == cnt_ff);
               REQ_REMOVE_FRONT: ctrl[i].shift_left = !is_empty;
               default: ;
            endcase
         end
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_data;
      logic signed [VALUE_W-1:0] right_data;
      if (g == 0) begin : g_first
         assign left_data = op_ff.value;
      end else begin : g_mid
         assign left_data = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_data = cell_data[g];
      end else begin : g_inner
         assign right_data = cell_data[g+1];
      end
      deqvs_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[g]),
         .left_data  (left_data),
         .right_data (right_data),
         .new_value  (op_ff.value),
         .key        (op_ff.value),
         .data       (cell_data[g]),
         .match      (cell_match[g])
      );
   end

   // pick the back element and the first occupied match
   always_comb begin
      back_value = '0;
      hit        = 1'b0;
      hit_idx    = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CW'(i) == last_idx) begin
            back_value = cell_data[i];
         end
      end
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_match[i] && (CW'(i) < cnt_ff)) begin
            hit     = 1'b1;
            hit_idx = IW'(i);
         end
      end
   end

   always_comb begin
      op_valid_in  = op_valid_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      hit_wide     = 32'(hit_idx);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (req_valid && !op_valid_ff) begin
         op_valid_in = 1'b1;
         op_in       = req_payload;
      end

      if (execute) begin
         op_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         case (op_ff.req_type) inside
            REQ_INSERT_FRONT, REQ_INSERT_BACK: begin
               if (is_full) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
            REQ_REMOVE_FRONT: begin
               if (is_empty) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  rsp_in.removed_value = cell_data[0];
                  cnt_in = last_idx;
               end
            end
            REQ_REMOVE_BACK: begin
               if (is_empty) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  rsp_in.removed_value = back_value;
                  cnt_in = last_idx;
               end
            end
            REQ_SEARCH: begin
               rsp_in.found = hit;
               if (hit) begin
                  rsp_in.position = hit_wide[POS_W-1:0];
               end
            end
            default: ;
         endcase
      end
      cnt_wide = 32'(cnt_in);
      if (execute) begin
         rsp_in.count = cnt_wide[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_valid_ff  <= op_valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

/* rtl/deqvs_cell.sv */
`default_nettype none
module deqvs_cell
   import deqvs_pkg::*;
(
   input  wire logic                      clock,
   input  wire cell_ctrl_type             ctrl,
   input  wire logic signed [VALUE_W-1:0] left_data,
   input  wire logic signed [VALUE_W-1:0] right_data,
   input  wire logic signed [VALUE_W-1:0] new_value,
   input  wire logic signed [VALUE_W-1:0] key,
   output logic signed [VALUE_W-1:0]      data,
   output logic                           match
);

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_right) begin
         data_in = left_data;
      end else if (ctrl.shift_left) begin
         data_in = right_data;
      end else if (ctrl.load) begin
         data_in = new_value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (data_ff == key);

endmodule
`default_nettype wire

/* dv/tb_deque_with_value_search.sv */
`timescale 1ns / 1ps
module tb_deque_with_value_search
   import deqvs_pkg::*;
();

   localparam int DEPTH          = 16;
   localparam int RANDOM_ITEMS   = 925;
   localparam int DRAIN_EVERY    = 250;
   localparam int SETTLE_CYCLES  = 8;
   localparam int CYCLE_LIMIT    = 200000;

   // req_type codes the block ignores
   localparam logic [REQ_W-1:0] REQ_UNDEFINED_FIRST = 3'd5;
   localparam logic [REQ_W-1:0] REQ_UNDEFINED_LAST  = 3'd7;

   typedef struct {
      req_payload_type request;
      bit              known;
      rsp_payload_type response;
   } directed_step_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   logic signed [VALUE_W-1:0] deque_contents[$];
   rsp_payload_type           pending_responses[$];
   directed_step_type         directed_steps[$];

   int mismatches;
   int cycle_count;
   int stall_left;
   bit quiet_sender;
   bit quiet_receiver;

   deque_with_value_search #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   // Apply one request to the deque and return the response it should produce.
   function automatic rsp_payload_type next_deque_response(input req_payload_type r);
      rsp_payload_type o;
      o = '0;
      case (r.req_type)
         REQ_INSERT_FRONT: begin
            if (deque_contents.size() >= DEPTH) o.status = STAT_FULL;
            else deque_contents.push_front(r.value);
         end
         REQ_INSERT_BACK: begin
            if (deque_contents.size() >= DEPTH) o.status = STAT_FULL;
            else deque_contents.push_back(r.value);
         end
         REQ_REMOVE_FRONT: begin
            if (deque_contents.size() == 0) o.status = STAT_EMPTY;
            else o.removed_value = deque_contents.pop_front();
         end
         REQ_REMOVE_BACK: begin
            if (deque_contents.size() == 0) o.status = STAT_EMPTY;
            else o.removed_value = deque_contents.pop_back();
         end
         REQ_SEARCH: begin
            for (int i = 0; i < deque_contents.size(); i++) begin
               if (!o.found && deque_contents[i] == r.value) begin
                  o.found    = 1'b1;
                  o.position = POS_W'(i);
               end
            end
         end
         default: ;
      endcase
      o.count = COUNT_W'(deque_contents.size());
      return o;
   endfunction

   function automatic directed_step_type make_step(
      input logic [REQ_W-1:0]   kind,
      input logic [VALUE_W-1:0] val,
      input bit                 known,
      input logic [VALUE_W-1:0] removed,
      input logic               hit,
      input logic [POS_W-1:0]   pos,
      input logic [STAT_W-1:0]  stat,
      input logic [COUNT_W-1:0] cnt
   );
      directed_step_type s;
      s.request.req_type        = kind;
      s.request.value           = val;
      s.known                   = known;
      s.response.removed_value  = removed;
      s.response.found          = hit;
      s.response.position       = pos;
      s.response.status         = stat;
      s.response.count          = cnt;
      return s;
   endfunction

   // Hold the request until accepted, then record what it should produce.
   task automatic send_request(input req_payload_type r, input bit known,
                               input rsp_payload_type known_rsp);
      int              gap;
      rsp_payload_type predicted;
      if ($urandom_range(0, 39) == 0) quiet_sender = !quiet_sender;
      gap = quiet_sender ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = next_deque_response(r);
      pending_responses.push_back(known ? known_rsp : predicted);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_responses.size() != 0);
   endtask

   // Check accepted responses and draw receiver hold-offs.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               $error("unexpected response: removed_value %0d count %0d",
                      rsp_payload.removed_value, rsp_payload.count);
               mismatches++;
            end else begin
               want = pending_responses.pop_front();
               if (rsp_payload.removed_value !== want.removed_value) begin
                  $error("removed_value: expected %0d, got %0d",
                         want.removed_value, rsp_payload.removed_value);
                  mismatches++;
               end
               if (rsp_payload.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_payload.found);
                  mismatches++;
               end
               if (rsp_payload.position !== want.position) begin
                  $error("position: expected %0d, got %0d",
                         want.position, rsp_payload.position);
                  mismatches++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
                  mismatches++;
               end
               if (rsp_payload.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_payload.count);
                  mismatches++;
               end
            end
            if ($urandom_range(0, 39) == 0) quiet_receiver = !quiet_receiver;
            stall_left = quiet_receiver ? 0 : $urandom_range(0, 8);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_deque_with_value_search NOT OK");
         $finish;
      end
   end

   initial begin
      req_payload_type r;
      int              counted;
      int              insert_pct;
      int              roll;
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      quiet_sender   = 1'b0;

      // empty store, ignored codes, extremes, fill to full, insert when full
      directed_steps.push_back(make_step(REQ_REMOVE_FRONT, 32'h0, 1, 0, 0, 0, STAT_EMPTY, 0));
      directed_steps.push_back(make_step(REQ_REMOVE_BACK, 32'hFFFFFFFF, 1, 0, 0, 0,
                                         STAT_EMPTY, 0));
      directed_steps.push_back(make_step(REQ_SEARCH, 32'h0, 1, 0, 0, 0, STAT_DONE, 0));
      directed_steps.push_back(make_step(REQ_UNDEFINED_FIRST, 32'h7FFFFFFF, 1, 0, 0, 0,
                                         STAT_DONE, 0));
      directed_steps.push_back(make_step(REQ_INSERT_FRONT, 32'h7FFFFFFF, 1, 0, 0, 0,
                                         STAT_DONE, 1));
      directed_steps.push_back(make_step(REQ_INSERT_BACK, 32'h80000000, 1, 0, 0, 0,
                                         STAT_DONE, 2));
      directed_steps.push_back(make_step(REQ_SEARCH, 32'h80000000, 1, 0, 1, 1, STAT_DONE, 2));
      directed_steps.push_back(make_step(REQ_INSERT_FRONT, 32'h00000000, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_BACK, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_FRONT, 32'h00000001, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_BACK, 32'h55555555, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_FRONT, 32'hAAAAAAAA, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_BACK, 32'h12345678, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_FRONT, 32'hFFFFFFFE, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_BACK, 32'h80000001, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_FRONT, 32'h7FFFFFFE, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_BACK, 32'h0F0F0F0F, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_FRONT, 32'hF0F0F0F0, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_BACK, 32'h00000002, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_FRONT, 32'hFFFF0000, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_BACK, 32'h0000FFFF, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_INSERT_FRONT, 32'h00000005, 1, 0, 0, 0,
                                         STAT_FULL, 16));
      directed_steps.push_back(make_step(REQ_SEARCH, 32'h0000FFFF, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_UNDEFINED_LAST, 32'h0, 1, 0, 0, 0, STAT_DONE, 16));
      directed_steps.push_back(make_step(REQ_REMOVE_FRONT, 32'h0, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(make_step(REQ_REMOVE_BACK, 32'h0, 0, 0, 0, 0, 0, 0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         send_request(directed_steps[i].request, directed_steps[i].known,
                      directed_steps[i].response);
      wait_until_drained();

      counted    = 0;
      insert_pct = 50;
      while (counted < RANDOM_ITEMS) begin
         // swing between filling, draining and balanced traffic
         if (counted % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       insert_pct = 15;
               1:       insert_pct = 50;
               default: insert_pct = 85;
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < 6)
            r.req_type = REQ_W'($urandom_range(REQ_UNDEFINED_FIRST, REQ_UNDEFINED_LAST));
         else if (roll < 30)
            r.req_type = REQ_SEARCH;
         else if ($urandom_range(0, 99) < insert_pct)
            r.req_type = $urandom_range(0, 1) ? REQ_INSERT_BACK : REQ_INSERT_FRONT;
         else
            r.req_type = $urandom_range(0, 1) ? REQ_REMOVE_BACK : REQ_REMOVE_FRONT;

         roll = $urandom_range(0, 99);
         if (roll < 40 && deque_contents.size() != 0)
            r.value = deque_contents[$urandom_range(0, deque_contents.size() - 1)];
         else if (roll < 70)
            r.value = VALUE_W'($signed($urandom_range(0, 7)) - 4);
         else
            r.value = $urandom;

         send_request(r, 1'b0, '0);
         counted++;
         if (counted % DRAIN_EVERY == 0) wait_until_drained();
      end

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb_deque_with_value_search OK");
      else
         $display("tb_deque_with_value_search NOT OK");
      $finish;
   end

endmodule
